### src/lapp_pkg.sv
// Package for the laser antenna particle push pipeline.
// Holds the shared widths, the side-band and config structs and the register index codes.
// No dependencies.
`default_nettype none
package lapp_pkg;
    localparam int VW        = 42;  // signed velocity, Q.39 fraction of c
    localparam int GW        = 36;  // Lorentz factor, Q.16
    localparam int RW        = 47;  // radicand 2^46 - s^2
    localparam int ROOTW     = 24;
    localparam int PW        = VW + GW;
    localparam int SQ_STAGES = 6;
    localparam int SQ_STEPS  = 4;
    localparam int DV_STAGES = 6;
    localparam int DV_STEPS  = 6;
    localparam int DV_SKIP   = 11;  // leading quotient bits that are always zero

    localparam logic [23:0] GAMMA_ONE = 24'd65536;

    typedef enum logic [2:0] {
        CFG_MOBILITY     = 3'd0,
        CFG_BOOST_GAMMA  = 3'd1,
        CFG_BOOST_BETA   = 3'd2,
        CFG_LIGHT_STEP   = 3'd3,
        CFG_POLARIZATION = 3'd4,
        CFG_DIRECTION    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] mobility;
        logic [23:0] boost_gamma;
        logic [23:0] boost_beta;
        logic [31:0] light_step;
        logic [47:0] polarization;
        logic [47:0] direction;
    } t_cfg;

    typedef struct packed {
        logic [2:0][VW-1:0] v;
        logic [2:0][31:0]   pos;
        logic               err;
        logic               last;
    } t_side;
endpackage
`default_nettype wire

### src/lapp_front.sv
// Front stages: amplitude magnitude, speed product with saturation, velocity and radicand.
// Three register stages. Depends on lapp_pkg.
`default_nettype none
module lapp_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [2:0][31:0]     i_pos,
    input  wire logic                 i_wpos,
    input  wire logic [31:0]          i_amp,
    input  wire logic                 i_last,
    input  wire lapp_pkg::t_cfg       i_cfg,
    output logic                      o_valid,
    output lapp_pkg::t_side           o_side,
    output logic [lapp_pkg::RW-1:0]   o_rad
);
    import lapp_pkg::*;

    logic             r1_valid, r2_valid;
    logic [31:0]      r1_amag;
    logic             r1_neg, r2_neg;
    logic [2:0][31:0] r1_pos, r2_pos;
    logic             r1_last, r2_last;
    logic [22:0]      r2_smag;
    logic             r2_err;

    logic [63:0]      prod;
    logic             sat;
    logic signed [24:0] s;
    logic             boost;
    logic signed [40:0] sp [3];
    logic signed [40:0] bn [3];
    logic [2:0][VW-1:0] n_v;
    logic [45:0]      sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
    end

    assign prod = 64'(i_cfg.mobility) * 64'(r1_amag);
    assign sat  = |prod[63:55];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_amag <= i_amp[31] ? 32'(-i_amp) : i_amp;
            r1_neg  <= ~i_wpos ^ i_amp[31];
            r1_pos  <= i_pos;
            r1_last <= i_last;
            r2_smag <= sat ? 23'h7FFFFF : prod[54:32];
            r2_err  <= sat;
            r2_neg  <= r1_neg;
            r2_pos  <= r1_pos;
            r2_last <= r1_last;
        end
    end

    assign s     = r2_neg ? -$signed({2'b00, r2_smag}) : $signed({2'b00, r2_smag});
    assign boost = i_cfg.boost_gamma > GAMMA_ONE;
    assign sq    = 46'(r2_smag) * 46'(r2_smag);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sp[i]  = s * $signed(i_cfg.polarization[16*i +: 16]);
            bn[i]  = $signed({1'b0, i_cfg.boost_beta}) * $signed(i_cfg.direction[16*i +: 16]);
            n_v[i] = (VW'(sp[i]) <<< 1) - (boost ? VW'(bn[i]) : VW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side.v    <= n_v;
            o_side.pos  <= r2_pos;
            o_side.err  <= r2_err;
            o_side.last <= r2_last;
            o_rad       <= (RW'(1) << (RW - 1)) - RW'(sq);
        end
    end
endmodule
`default_nettype wire

### src/lapp_isqrt.sv
// Pipelined floor square root, a few result bits per stage, side band carried along.
// Depends on lapp_pkg.
`default_nettype none
module lapp_isqrt (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire lapp_pkg::t_side        i_side,
    input  wire logic [lapp_pkg::RW-1:0] i_rad,
    output logic                        o_valid,
    output lapp_pkg::t_side             o_side,
    output logic [lapp_pkg::ROOTW-1:0]  o_root
);
    import lapp_pkg::*;

    logic [SQ_STAGES-1:0] r_valid;
    t_side                r_side [SQ_STAGES];
    logic [RW-1:0]        r_x    [SQ_STAGES];
    logic [RW:0]          r_r    [SQ_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[SQ_STAGES-2:0], i_valid};
        end
    end

    for (genvar st = 0; st < SQ_STAGES; st++) begin : g_st
        logic [RW-1:0] x_in, n_x;
        logic [RW:0]   r_in, n_r, b;
        t_side         side_in;

        if (st == 0) begin : g_first
            assign x_in    = i_rad;
            assign r_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign x_in    = r_x[st-1];
            assign r_in    = r_r[st-1];
            assign side_in = r_side[st-1];
        end

        always_comb begin
            n_x = x_in;
            n_r = r_in;
            b   = '0;
            for (int j = 0; j < SQ_STEPS; j++) begin
                b = (RW+1)'(1) << (RW - 1 - 2 * (st * SQ_STEPS + j));
                if ({1'b0, n_x} >= n_r + b) begin
                    n_x = n_x - RW'(n_r + b);
                    n_r = (n_r >> 1) + b;
                end else begin
                    n_r = n_r >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[st]    <= n_x;
                r_r[st]    <= n_r;
                r_side[st] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];
    assign o_root  = r_r[SQ_STAGES-1][ROOTW-1:0];
endmodule
`default_nettype wire

### src/lapp_div.sv
// Pipelined restoring divider: gamma = (boost_gamma << 23) / root, several bits per stage.
// Depends on lapp_pkg.
`default_nettype none
module lapp_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire lapp_pkg::t_side         i_side,
    input  wire logic [lapp_pkg::ROOTW-1:0] i_root,
    input  wire logic [23:0]             i_gamma,
    output logic                         o_valid,
    output lapp_pkg::t_side              o_side,
    output logic [lapp_pkg::GW-1:0]      o_gam
);
    import lapp_pkg::*;

    logic [DV_STAGES-1:0] r_valid;
    t_side                r_side [DV_STAGES];
    logic [ROOTW-1:0]     r_root [DV_STAGES];
    logic [ROOTW-1:0]     r_rem  [DV_STAGES];
    logic [GW-1:0]        r_q    [DV_STAGES];
    logic [RW-1:0]        dvd;

    assign dvd = {i_gamma, 23'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DV_STAGES-2:0], i_valid};
        end
    end

    for (genvar st = 0; st < DV_STAGES; st++) begin : g_st
        logic [ROOTW-1:0] rem_in, root_in, n_rem;
        logic [GW-1:0]    q_in, n_q;
        logic [ROOTW:0]   t;
        t_side            side_in;

        if (st == 0) begin : g_first
            assign rem_in  = ROOTW'(dvd[RW-1 -: DV_SKIP]);
            assign q_in    = '0;
            assign root_in = i_root;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[st-1];
            assign q_in    = r_q[st-1];
            assign root_in = r_root[st-1];
            assign side_in = r_side[st-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_q   = q_in;
            t     = '0;
            for (int j = 0; j < DV_STEPS; j++) begin
                t = {n_rem, dvd[GW - 1 - (st * DV_STEPS + j)]};
                if (t >= {1'b0, root_in}) begin
                    n_rem = ROOTW'(t - {1'b0, root_in});
                    n_q   = {n_q[GW-2:0], 1'b1};
                end else begin
                    n_rem = t[ROOTW-1:0];
                    n_q   = {n_q[GW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[st]  <= n_rem;
                r_q[st]    <= n_q;
                r_root[st] <= root_in;
                r_side[st] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[DV_STAGES-1];
    assign o_side  = r_side[DV_STAGES-1];
    assign o_gam   = r_q[DV_STAGES-1];
endmodule
`default_nettype wire

### src/lapp_mul.sv
// Two-stage unsigned multiplier, 42 x 36 bits, built from four registered partial products.
// Depends on lapp_pkg.
`default_nettype none
module lapp_mul (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [lapp_pkg::VW-1:0] i_a,
    input  wire logic [lapp_pkg::GW-1:0] i_b,
    output logic [lapp_pkg::PW-1:0]   o_p
);
    import lapp_pkg::*;

    localparam int AL = VW / 2;
    localparam int BL = GW / 2;
    localparam int PP = (VW - AL) + (GW - BL);

    logic [PP-1:0] r_hh, r_hl, r_lh, r_ll;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= PP'(i_a[VW-1:AL]) * PP'(i_b[GW-1:BL]);
            r_hl <= PP'(i_a[VW-1:AL]) * PP'(i_b[BL-1:0]);
            r_lh <= PP'(i_a[AL-1:0])  * PP'(i_b[GW-1:BL]);
            r_ll <= PP'(i_a[AL-1:0])  * PP'(i_b[BL-1:0]);
            o_p  <= (PW'(r_hh) << (AL + BL)) + (PW'(r_hl) << AL)
                  + (PW'(r_lh) << BL) + PW'(r_ll);
        end
    end
endmodule
`default_nettype wire

### src/laser_antenna_particle_push.sv
// Laser antenna particle push, top level. Throughput one particle per cycle unless the output
// stalls; the square root and divider pipelines set the depth. Output stall freezes the whole
// pipeline; a new request is taken whenever the output register is empty or being drained.
// Synchronous active-low reset clears valids and resets config to zero, boost_gamma to one.
// Depends on lapp_pkg, lapp_front, lapp_isqrt, lapp_div, lapp_mul.
`default_nettype none
module laser_antenna_particle_push (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // pos_x, pos_y, pos_z, weight_positive, field_amplitude, zero pad
    input  wire logic [135:0] i_s_axis_tdata,
    input  wire logic         i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // mom_x, mom_y, mom_z, new_x, new_y, new_z, speed_error, zero pad
    output logic [199:0]      o_m_axis_tdata,
    output logic              o_m_axis_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [47:0]  i_cfg_data
);
    import lapp_pkg::*;

    t_cfg             r_cfg;
    logic             en;
    logic             f_valid, q_valid, d_valid;
    t_side            f_side, q_side, d_side;
    logic [RW-1:0]    f_rad;
    logic [ROOTW-1:0] q_root;
    logic [GW-1:0]    d_gam;
    logic [2:0][VW-1:0] vmag;
    logic [2:0][PW-1:0] prod_g, prod_l;
    logic             r_m1_valid, r_m2_valid;
    t_side            r_m1_side, r_m2_side;
    logic [2:0]       r_m1_neg, r_m2_neg;
    logic [2:0][31:0] mom, np;
    logic [38:0]      mq [3];
    logic [38:0]      dq [3];
    logic [30:0]      msat [3];
    logic signed [40:0] ps [3];
    logic             r_o_valid;
    logic [199:0]     r_o_data;
    logic             r_o_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mobility     <= '0;
            r_cfg.boost_gamma  <= GAMMA_ONE;
            r_cfg.boost_beta   <= '0;
            r_cfg.light_step   <= '0;
            r_cfg.polarization <= '0;
            r_cfg.direction    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MOBILITY:     r_cfg.mobility     <= i_cfg_data[31:0];
                CFG_BOOST_GAMMA:  r_cfg.boost_gamma  <= i_cfg_data[23:0];
                CFG_BOOST_BETA:   r_cfg.boost_beta   <= i_cfg_data[23:0];
                CFG_LIGHT_STEP:   r_cfg.light_step   <= i_cfg_data[31:0];
                CFG_POLARIZATION: r_cfg.polarization <= i_cfg_data;
                CFG_DIRECTION:    r_cfg.direction    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en              = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    lapp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_pos   (i_s_axis_tdata[95:0]),
        .i_wpos  (i_s_axis_tdata[96]),
        .i_amp   (i_s_axis_tdata[128:97]),
        .i_last  (i_s_axis_tlast),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_rad   (f_rad)
    );

    lapp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_rad   (f_rad),
        .o_valid (q_valid),
        .o_side  (q_side),
        .o_root  (q_root)
    );

    lapp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_side  (q_side),
        .i_root  (q_root),
        .i_gamma (r_cfg.boost_gamma),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_gam   (d_gam)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vmag[i] = d_side.v[i][VW-1] ? VW'(-d_side.v[i]) : d_side.v[i];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_mul
        lapp_mul u_mul_g (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (vmag[i]),
            .i_b   (d_gam),
            .o_p   (prod_g[i])
        );
        lapp_mul u_mul_l (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (vmag[i]),
            .i_b   (GW'(r_cfg.light_step)),
            .o_p   (prod_l[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_m1_valid <= d_valid;
            r_m2_valid <= r_m1_valid;
            r_o_valid  <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_side <= d_side;
            r_m1_neg  <= {d_side.v[2][VW-1], d_side.v[1][VW-1], d_side.v[0][VW-1]};
            r_m2_side <= r_m1_side;
            r_m2_neg  <= r_m1_neg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mq[i]   = prod_g[i][PW-1:39];
            dq[i]   = prod_l[i][PW-1:39];
            msat[i] = (|mq[i][38:31]) ? 31'h7FFF_FFFF : mq[i][30:0];
            mom[i]  = r_m2_neg[i] ? 32'(-{1'b0, msat[i]}) : {1'b0, msat[i]};
            ps[i]   = r_m2_neg[i]
                    ? $signed(41'(signed'(r_m2_side.pos[i]))) - $signed({2'b00, dq[i]})
                    : $signed(41'(signed'(r_m2_side.pos[i]))) + $signed({2'b00, dq[i]});
            if (ps[i][40:31] != {10{ps[i][40]}}) begin
                np[i] = ps[i][40] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                np[i] = ps[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= {7'b0, r_m2_side.err, np[2], np[1], np[0], mom[2], mom[1], mom[0]};
            r_o_last <= r_m2_side.last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;
endmodule
`default_nettype wire

### src/lapp_check.sv
// Port-level checker for laser_antenna_particle_push, bound to the top level.
// No dependencies beyond the top level's ports.
`default_nettype none
module lapp_check (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [199:0] o_m_axis_tdata,
    input wire logic         o_m_axis_tlast,
    input wire logic         o_cfg_ready
);
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("request refused with empty output");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");
endmodule

bind laser_antenna_particle_push lapp_check u_lapp_check (.*);
`default_nettype wire
